// ===== sv/aes_block_encrypt_macros.svh =====
// Assertion macros for the AES block encryption checker.
`ifndef AES_BLOCK_ENCRYPT_MACROS_SVH
`define AES_BLOCK_ENCRYPT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define AES_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Property checked on every clock edge, reset included.
`define AES_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ===== sv/aes_pkg.sv =====
// Shared types, constants and GF(2^8) functions for the AES block encryption core.
`timescale 1ns / 1ps
package aes_pkg;

  localparam int unsigned KeyBytesDefault = 16;
  localparam logic [7:0] GfPoly = 8'h1B;
  localparam logic [7:0] GfMsb = 8'h80;
  localparam logic [7:0] RconFirst = 8'h01;

  typedef struct packed {
    logic [63:0] plaintext_hi;
    logic [63:0] plaintext_lo;
    logic [63:0] key_w0;
    logic [63:0] key_w1;
    logic [63:0] key_w2;
    logic [63:0] key_w3;
  } aes_in_t;

  typedef struct packed {
    logic [63:0] ciphertext_hi;
    logic [63:0] ciphertext_lo;
  } aes_out_t;

  function automatic int unsigned nk_words(input int unsigned key_bytes);
    return (key_bytes >= 32) ? 8 : ((key_bytes >= 24) ? 6 : 4);
  endfunction

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    logic [7:0] r;
    r = {a[6:0], 1'b0};
    if ((a & GfMsb) != 8'h00) begin
      r = r ^ GfPoly;
    end
    return r;
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // State byte b sits at bits 127-8b.
  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] t;
    int src;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        src = 4 * ((c + r) & 3) + r;
        t[127 - 8 * (4 * c + r) -: 8] = SBOX[s[127 - 8 * src -: 8]];
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] col_mix(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3, all;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127 - 32 * c -: 8];
      a1 = s[119 - 32 * c -: 8];
      a2 = s[111 - 32 * c -: 8];
      a3 = s[103 - 32 * c -: 8];
      all = a0 ^ a1 ^ a2 ^ a3;
      t[127 - 32 * c -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
      t[119 - 32 * c -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
      t[111 - 32 * c -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
      t[103 - 32 * c -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
    end
    return t;
  endfunction

endpackage

// ===== sv/aes_round.sv =====
// One pipelined AES round: cipher state step plus the matching key schedule step.
`timescale 1ns / 1ps
module aes_round import aes_pkg::*; #(
  parameter int unsigned NkWords = 4,
  parameter int unsigned Round   = 1,
  parameter bit          IsLast  = 1'b0
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic [127:0]            state_i,
  input  logic [32*NkWords-1:0]   win_i,
  input  logic [7:0]              rcon_i,
  output logic                    valid_o,
  output logic [127:0]            state_o,
  output logic [32*NkWords-1:0]   win_o,
  output logic [7:0]              rcon_o
);

  // Window holds words w[4r-4 .. 4r+Nk-5], oldest at the top; the round key
  // is w[4r .. 4r+3] and four new words w[4r+Nk-4 .. 4r+Nk-1] are made.
  localparam int unsigned WinW = 32 * NkWords;
  localparam int unsigned Base = 4 * Round + NkWords - 4;
  localparam int unsigned Phase [4] = '{
    Base % NkWords, (Base + 1) % NkWords, (Base + 2) % NkWords, (Base + 3) % NkWords
  };

  logic [WinW-1:0]    win_d, win_q;
  logic [7:0]         rcon_d, rcon_q;
  logic [127:0]       state_d, state_q;
  logic [127:0]       rkey;
  logic               valid_q;

  always_comb begin
    logic [31:0] w [8 + 4];
    logic [31:0] t;
    logic [7:0]  rc;
    for (int k = 0; k < 12; k++) begin
      w[k] = '0;
    end
    for (int k = 0; k < int'(NkWords); k++) begin
      w[k] = win_i[WinW - 1 - 32 * k -: 32];
    end
    rc = rcon_i;
    for (int j = 0; j < 4; j++) begin
      t = w[int'(NkWords) + j - 1];
      if (Phase[j] == 0) begin
        t = sub_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = xtime(rc);
      end else if (NkWords > 6 && Phase[j] == 4) begin
        t = sub_word(t);
      end
      w[int'(NkWords) + j] = w[j] ^ t;
    end
    rcon_d = rc;
    win_d = '0;
    for (int k = 0; k < int'(NkWords); k++) begin
      win_d[WinW - 1 - 32 * k -: 32] = w[k + 4];
    end
    rkey = {w[4], w[5], w[6], w[7]};
    if (IsLast) begin
      state_d = sub_shift(state_i) ^ rkey;
    end else begin
      state_d = col_mix(sub_shift(state_i)) ^ rkey;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      state_q <= state_d;
      win_q   <= win_d;
      rcon_q  <= rcon_d;
    end
  end

  assign valid_o = valid_q;
  assign state_o = state_q;
  assign win_o   = win_q;
  assign rcon_o  = rcon_q;

endmodule

// ===== sv/aes_block_encrypt.sv =====
// Top level of the pipelined AES block encryption core.
//
// Usage: present a plaintext block and cipher key on in_data_i with
// in_valid_i; the item is taken when in_ready_o is high.
// The ciphertext appears on out_data_o with out_valid_o and leaves when
// out_ready_i is high.
// Pipeline: one input register stage holding the initial key addition,
// then one register stage per round (10, 12 or 14 for 16, 24 or 32-byte
// keys). Throughput: one item per cycle while results are taken; each round
// stage carries its own S-box copies and key schedule step, so nothing is
// shared between items.
// Stall: a stage holds only when it and every later stage hold items and the
// last stage's result is not taken; bubbles still move on, so a new item
// enters while the pipe is not full, and in_ready_o drops only when it is.
// Reset: clears all stage valid bits; payload registers are not reset.
// KEY_BYTES below 24 acts as 16, 24 to 31 as 24, 32 and up as 32.
`timescale 1ns / 1ps
module aes_block_encrypt import aes_pkg::*; #(
  parameter int unsigned KEY_BYTES = KeyBytesDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  aes_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output aes_out_t out_data_o
);

  localparam int unsigned Nk   = nk_words(KEY_BYTES);
  localparam int unsigned Nr   = Nk + 6;
  localparam int unsigned WinW = 32 * Nk;

  logic [Nr:0]       valid;
  logic [127:0]      state [Nr + 1];
  logic [WinW-1:0]   win   [Nr + 1];
  logic [7:0]        rcon  [Nr + 1];
  logic [Nr:0]       en;

  // A stage advances when its output slot is free or moving on.
  assign en[Nr] = out_ready_i || !valid[Nr];
  for (genvar g = Nr; g > 0; g--) begin : g_en
    assign en[g - 1] = en[g] || !valid[g - 1];
  end
  assign in_ready_o = en[0];

  // Stage zero: load key window and apply the first round key.
  logic [255:0]    key_all;
  logic [WinW-1:0] win0_d;
  logic [127:0]    state0_d;
  logic [127:0]    state0_q;
  logic [WinW-1:0] win0_q;
  logic [7:0]      rcon0_q;
  logic            valid0_q;

  assign key_all  = {in_data_i.key_w0, in_data_i.key_w1, in_data_i.key_w2, in_data_i.key_w3};
  assign win0_d   = key_all[255 -: WinW];
  assign state0_d = {in_data_i.plaintext_hi, in_data_i.plaintext_lo} ^ key_all[255:128];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid0_q <= 1'b0;
    end else if (en[0]) begin
      valid0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      state0_q <= state0_d;
      win0_q   <= win0_d;
      rcon0_q  <= RconFirst;
    end
  end

  assign valid[0] = valid0_q;
  assign state[0] = state0_q;
  assign win[0]   = win0_q;
  assign rcon[0]  = rcon0_q;

  for (genvar r = 1; r <= Nr; r++) begin : g_round
    aes_round #(
      .NkWords(Nk),
      .Round  (r),
      .IsLast (r == Nr)
    ) u_round (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en[r]),
      .valid_i(valid[r - 1]),
      .state_i(state[r - 1]),
      .win_i  (win[r - 1]),
      .rcon_i (rcon[r - 1]),
      .valid_o(valid[r]),
      .state_o(state[r]),
      .win_o  (win[r]),
      .rcon_o (rcon[r])
    );
  end

  assign out_valid_o = valid[Nr];
  assign out_data_o  = '{ciphertext_hi: state[Nr][127:64], ciphertext_lo: state[Nr][63:0]};

endmodule

// ===== sv/aes_block_encrypt_checker.sv =====
// Port-level assertion checker for the AES block encryption core, with its bind.
`timescale 1ns / 1ps
`include "aes_block_encrypt_macros.svh"
module aes_block_encrypt_checker import aes_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input aes_in_t  in_data_i,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input aes_out_t out_data_o
);

  `AES_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o), "stalled result changed")
  `AES_ASSERT(a_ready_free, clk_i, rst_ni, !out_valid_o |-> in_ready_o, "input blocked with empty output")
  `AES_ASSERT(a_in_hold, clk_i, rst_ni, in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i), "waiting item changed")
  `AES_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |=> !out_valid_o, "result valid after reset")

endmodule

bind aes_block_encrypt aes_block_encrypt_checker u_checker (.*);

// ===== bench/tb.sv =====
// Self-checking bench for the pipelined AES block encryption core.
`timescale 1ns / 1ps
module tb;
  import aes_pkg::*;

  localparam int unsigned KEY_BYTES = KeyBytesDefault;
  localparam int NK = (KEY_BYTES >= 32) ? 8 : ((KEY_BYTES >= 24) ? 6 : 4);
  localparam int NR = NK + 6;
  localparam int LATENCY = NR + 1;
  localparam int N_RANDOM = 2000;
  localparam longint CYCLE_LIMIT = 400000;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  aes_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  aes_out_t out_data_o;

  aes_block_encrypt #(.KEY_BYTES(KEY_BYTES)) u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  aes_in_t  pending_blocks[$];
  aes_out_t expected_cipher[$];
  int       n_errors = 0;
  int       n_sent = 0;
  int       n_checked = 0;
  bit       stim_done = 1'b0;
  bit       hold_sink = 1'b0;
  longint   cycle_count = 0;

  // Forward S-box, built from GF(2^8) inversion and the affine map.
  logic [7:0] sbox_tab[256];

  function automatic logic [7:0] gf_double(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = gf_double(a);
    end
    return p;
  endfunction

  function automatic logic [7:0] affine(input logic [7:0] x);
    logic [7:0] y;
    for (int i = 0; i < 8; i++)
      y[i] = x[i] ^ x[(i + 4) % 8] ^ x[(i + 5) % 8] ^ x[(i + 6) % 8] ^ x[(i + 7) % 8];
    return y ^ 8'h63;
  endfunction

  initial begin
    sbox_tab[0] = affine(8'h00);
    for (int a = 1; a < 256; a++)
      for (int b = 1; b < 256; b++)
        if (gf_mul(a[7:0], b[7:0]) == 8'h01) sbox_tab[a] = affine(b[7:0]);
  end

  function automatic logic [31:0] subst_word(input logic [31:0] w);
    return {sbox_tab[w[31:24]], sbox_tab[w[23:16]], sbox_tab[w[15:8]], sbox_tab[w[7:0]]};
  endfunction

  // Bytes held as an array: byte b is row b%4, column b/4.
  function automatic aes_out_t encrypt_block(input aes_in_t item);
    logic [31:0] ks[60];
    logic [63:0] kin[4];
    logic [7:0]  st[16], tmp[16];
    logic [7:0]  rcon, a0, a1, a2, a3, all;
    logic [31:0] t;
    aes_out_t    res;
    kin = '{item.key_w0, item.key_w1, item.key_w2, item.key_w3};
    rcon = 8'h01;
    for (int i = 0; i < NK; i++)
      ks[i] = i[0] ? kin[i / 2][31:0] : kin[i / 2][63:32];
    for (int i = NK; i < 4 * (NR + 1); i++) begin
      t = ks[i - 1];
      if (i % NK == 0) begin
        t = subst_word({t[23:0], t[31:24]}) ^ {rcon, 24'h0};
        rcon = gf_double(rcon);
      end else if (NK > 6 && i % NK == 4) begin
        t = subst_word(t);
      end
      ks[i] = ks[i - NK] ^ t;
    end
    for (int i = 0; i < 8; i++) begin
      st[i] = item.plaintext_hi[63 - 8 * i -: 8];
      st[8 + i] = item.plaintext_lo[63 - 8 * i -: 8];
    end
    for (int rd = 0; rd <= NR; rd++) begin
      if (rd > 0) begin
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++)
            tmp[4 * c + r] = sbox_tab[st[4 * ((c + r) % 4) + r]];
        st = tmp;
        if (rd < NR) begin
          for (int c = 0; c < 4; c++) begin
            a0 = st[4 * c]; a1 = st[4 * c + 1]; a2 = st[4 * c + 2]; a3 = st[4 * c + 3];
            all = a0 ^ a1 ^ a2 ^ a3;
            st[4 * c] = a0 ^ all ^ gf_double(a0 ^ a1);
            st[4 * c + 1] = a1 ^ all ^ gf_double(a1 ^ a2);
            st[4 * c + 2] = a2 ^ all ^ gf_double(a2 ^ a3);
            st[4 * c + 3] = a3 ^ all ^ gf_double(a3 ^ a0);
          end
        end
      end
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++)
          st[4 * c + r] ^= ks[4 * rd + c][31 - 8 * r -: 8];
    end
    for (int i = 0; i < 8; i++) begin
      res.ciphertext_hi[63 - 8 * i -: 8] = st[i];
      res.ciphertext_lo[63 - 8 * i -: 8] = st[8 + i];
    end
    return res;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 50) return 0;
    if (sel < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic aes_in_t rand_block();
    aes_in_t it;
    it = {rand64(), rand64(), rand64(), rand64(), rand64(), rand64()};
    return it;
  endfunction

  // Driver: hold the item until accepted, then pull the next one after a gap.
  int src_gap = 0;
  bit src_pause = 1'b0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_cipher.push_back(encrypt_block(in_data_i));
        n_sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (src_gap > 0 || src_pause || pending_blocks.size() == 0) begin
          in_valid_i <= 1'b0;
          if (src_gap > 0) src_gap--;
        end else begin
          in_data_i <= pending_blocks.pop_front();
          in_valid_i <= 1'b1;
          src_gap = gap_len();
        end
      end
    end
  end

  // Monitor: check each result item against the oldest expectation.
  int sink_gap = 0;
  aes_out_t want;
  always @(posedge clk_i) begin
    cycle_count++;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_cipher.size() == 0) begin
          $display("%0t: unexpected item %h", $time, out_data_o);
          n_errors++;
        end else begin
          want = expected_cipher.pop_front();
          n_checked++;
          if (out_data_o.ciphertext_hi !== want.ciphertext_hi) begin
            $display("%0t: ciphertext_hi exp %h got %h", $time, want.ciphertext_hi,
                     out_data_o.ciphertext_hi);
            n_errors++;
          end
          if (out_data_o.ciphertext_lo !== want.ciphertext_lo) begin
            $display("%0t: ciphertext_lo exp %h got %h", $time, want.ciphertext_lo,
                     out_data_o.ciphertext_lo);
            n_errors++;
          end
        end
      end
      if (hold_sink) begin
        out_ready_i <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        sink_gap = gap_len();
      end
    end
  end

  // Watchdog: bail out if the run hangs.
  always @(posedge clk_i) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Stimulus, stalls and end of run.
  aes_in_t item;
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    // FIPS-197 appendix-style vector, then extremes.
    item = '0;
    item.plaintext_hi = 64'h00112233_44556677;
    item.plaintext_lo = 64'h8899aabb_ccddeeff;
    item.key_w0 = 64'h00010203_04050607;
    item.key_w1 = 64'h08090a0b_0c0d0e0f;
    item.key_w2 = 64'h10111213_14151617;
    item.key_w3 = 64'h18191a1b_1c1d1e1f;
    pending_blocks.push_back(item);
    pending_blocks.push_back('0);
    pending_blocks.push_back('1);
    item = '0; item.plaintext_hi = '1; item.plaintext_lo = '1;
    pending_blocks.push_back(item);
    item = '1; item.plaintext_hi = '0; item.plaintext_lo = '0;
    pending_blocks.push_back(item);
    // Unused key words must not matter: same block with different upper words.
    for (int i = 0; i < 4; i++) begin
      item = rand_block();
      pending_blocks.push_back(item);
      item.key_w3 = ~item.key_w3;
      if (NK < 6) item.key_w2 = ~item.key_w2;
      pending_blocks.push_back(item);
    end
    // Single set bits at random positions across the whole item.
    for (int i = 0; i < 8; i++) begin
      item = '0;
      item[$urandom_range(0, 383)] = 1'b1;
      pending_blocks.push_back(item);
    end
    // Back pressure: stop draining while the sender keeps offering items.
    hold_sink = 1'b1;
    for (int i = 0; i < 60; i++) pending_blocks.push_back(rand_block());
    repeat (150) @(posedge clk_i);
    hold_sink = 1'b0;
    // Sender pause until everything is drained.
    wait (pending_blocks.size() == 0 && !in_valid_i);
    src_pause = 1'b1;
    wait (expected_cipher.size() == 0);
    src_pause = 1'b0;
    for (int i = 0; i < N_RANDOM; i++) begin
      pending_blocks.push_back(rand_block());
      if (i % 200 == 199) wait (pending_blocks.size() < 20);
    end
    wait (pending_blocks.size() == 0 && !in_valid_i);
    stim_done = 1'b1;
    wait (expected_cipher.size() == 0);
    repeat (LATENCY + 10) @(posedge clk_i);
    $display("tb: %0d blocks encrypted with %0d-byte keys, %0d results checked", n_sent,
             4 * NK, n_checked);
    $display("tb: directed vectors, extremes, unused key words, stalls and random traffic");
    if (n_errors == 0 && expected_cipher.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
